// ----- hdl/hltp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the linear-probe hash table.
// No dependencies; used by every hltp_* module and the top level.
package hltp_pkg;

    localparam int TABLE_SIZE_DEF = 128;
    localparam int KEY_W          = 14;
    localparam int AGE_W          = 8;
    localparam int SLOT_W         = 7;

    typedef enum logic [1:0] {
        STATUS_INSERTED = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_FOUND    = 2'd2,
        STATUS_MISSING  = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        KIND_INSERT = 1'b0,
        KIND_SEARCH = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_REPORT
    } t_state;

    // One table entry as held in the slot RAM
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [AGE_W-1:0] age;
    } t_slot_word;

    localparam int WORD_W = $bits(t_slot_word);

    // One result transaction
    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [AGE_W-1:0]  age;
    } t_result;

endpackage

// ----- hdl/hltp_home_div.sv -----
`timescale 1ns / 1ps
// Home slot unit: key modulo TABLE_SIZE by reciprocal multiplication, registered quotient then registered remainder.
// Depends on hltp_pkg.
module hltp_home_div #(
    parameter int TABLE_SIZE = hltp_pkg::TABLE_SIZE_DEF,
    parameter int IDX_W      = $clog2(TABLE_SIZE)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [hltp_pkg::KEY_W-1:0] i_key,
    output logic                     o_done,
    output logic [IDX_W-1:0]         o_rem
);

    // floor(key / TABLE_SIZE) equals (key * RECIP) >> SHIFT for every KEY_W-bit key
    localparam int     SHIFT   = hltp_pkg::KEY_W + IDX_W;
    localparam int     RECIP_W = hltp_pkg::KEY_W + 2;
    localparam int     PROD_W  = hltp_pkg::KEY_W + RECIP_W;
    localparam longint RECIP_L = ((longint'(1) << SHIFT) + longint'(TABLE_SIZE) - 1)
                                 / longint'(TABLE_SIZE);
    localparam logic [RECIP_W-1:0]         RECIP   = RECIP_W'(RECIP_L);
    localparam logic [hltp_pkg::KEY_W-1:0] DIVISOR = hltp_pkg::KEY_W'(TABLE_SIZE);

    logic                       r_stage;
    logic                       r_done;
    logic [hltp_pkg::KEY_W-1:0] r_key;
    logic [hltp_pkg::KEY_W-1:0] r_quot;
    logic [IDX_W-1:0]           r_rem;
    logic [PROD_W-1:0]          prod;
    logic [hltp_pkg::KEY_W-1:0] quot;
    logic [hltp_pkg::KEY_W-1:0] rem_full;

    always_comb begin
        prod     = PROD_W'(i_key) * PROD_W'(RECIP);
        quot     = hltp_pkg::KEY_W'(prod >> SHIFT);
        // quotient times size never exceeds the key, so the product fits
        rem_full = r_key - hltp_pkg::KEY_W'(r_quot * DIVISOR);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_stage <= i_start;
            r_done  <= r_stage;
        end
        if (i_start) begin
            r_key  <= i_key;
            r_quot <= quot;
        end
        if (r_stage) begin
            r_rem <= rem_full[IDX_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- hdl/hltp_slot_ram.sv -----
`timescale 1ns / 1ps
// Simple dual-port slot RAM, one write and one registered read per cycle.
// Depends on hltp_pkg for default sizes.
module hltp_slot_ram #(
    parameter int DEPTH  = hltp_pkg::TABLE_SIZE_DEF,
    parameter int ADDR_W = $clog2(DEPTH),
    parameter int DATA_W = hltp_pkg::WORD_W
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/hltp_probe_fsm.sv -----
`timescale 1ns / 1ps
// Probe sequencer: clearing pass, hashing, read-check-write probe loop,
// occupancy count and result formation. Depends on hltp_pkg.
module hltp_probe_fsm #(
    parameter int TABLE_SIZE = hltp_pkg::TABLE_SIZE_DEF,
    parameter int IDX_W      = $clog2(TABLE_SIZE),
    parameter int CNT_W      = $clog2(TABLE_SIZE + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input transaction
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_kind,
    input  logic [hltp_pkg::KEY_W-1:0]   i_key,
    input  logic [hltp_pkg::AGE_W-1:0]   i_age,
    // home slot unit
    output logic                         o_div_start,
    input  logic                         i_div_done,
    input  logic [IDX_W-1:0]             i_div_rem,
    // slot RAM
    output logic                         o_ram_we,
    output logic [IDX_W-1:0]             o_ram_addr,
    output logic [hltp_pkg::WORD_W-1:0]  o_ram_wdata,
    output logic                         o_ram_re,
    input  logic [hltp_pkg::WORD_W-1:0]  i_ram_rdata,
    // result towards output register
    output logic                         o_res_valid,
    output hltp_pkg::t_result            o_res,
    input  logic                         i_res_ready
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_SIZE);

    hltp_pkg::t_state           r_state, n_state;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [IDX_W-1:0]           r_step, n_step;
    logic [CNT_W-1:0]           r_count, n_count;
    hltp_pkg::t_kind            r_kind, n_kind;
    logic [hltp_pkg::KEY_W-1:0] r_key, n_key;
    logic [hltp_pkg::AGE_W-1:0] r_age, n_age;
    hltp_pkg::t_result          r_res, n_res;

    hltp_pkg::t_slot_word              rd_word;
    hltp_pkg::t_slot_word              wr_word;
    logic [IDX_W-1:0]                  idx_next;
    logic [IDX_W+hltp_pkg::SLOT_W-1:0] idx_wide;

    always_comb begin
        rd_word     = hltp_pkg::t_slot_word'(i_ram_rdata);
        idx_next    = (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
        idx_wide    = {{hltp_pkg::SLOT_W{1'b0}}, r_idx};
        wr_word     = '0;
        n_state     = r_state;
        n_idx       = r_idx;
        n_step      = r_step;
        n_count     = r_count;
        n_kind      = r_kind;
        n_key       = r_key;
        n_age       = r_age;
        n_res       = r_res;
        o_in_stall  = 1'b1;
        o_div_start = 1'b0;
        o_ram_we    = 1'b0;
        o_ram_re    = 1'b0;
        o_res_valid = 1'b0;

        case (r_state)
            hltp_pkg::ST_CLEAR: begin
                o_ram_we = 1'b1;
                n_idx    = idx_next;
                if (r_idx == LAST_IDX) begin
                    n_state = hltp_pkg::ST_IDLE;
                end
            end
            hltp_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_kind      = hltp_pkg::t_kind'(i_kind);
                    n_key       = i_key;
                    n_age       = i_age;
                    o_div_start = 1'b1;
                    n_state     = hltp_pkg::ST_HASH;
                end
            end
            hltp_pkg::ST_HASH: begin
                if (i_div_done) begin
                    n_idx  = i_div_rem;
                    n_step = '0;
                    if (r_kind == hltp_pkg::KIND_INSERT && r_count >= FULL_CNT) begin
                        n_res   = '{hltp_pkg::STATUS_FULL, '0, '0};
                        n_state = hltp_pkg::ST_REPORT;
                    end else begin
                        n_state = hltp_pkg::ST_READ;
                    end
                end
            end
            hltp_pkg::ST_READ: begin
                o_ram_re = 1'b1;
                n_state  = hltp_pkg::ST_CHECK;
            end
            hltp_pkg::ST_CHECK: begin
                if (r_kind == hltp_pkg::KIND_INSERT && !rd_word.valid) begin
                    wr_word  = '{1'b1, r_key, r_age};
                    o_ram_we = 1'b1;
                    n_count  = r_count + 1'b1;
                    n_res    = '{hltp_pkg::STATUS_INSERTED,
                                 idx_wide[hltp_pkg::SLOT_W-1:0], '0};
                    n_state  = hltp_pkg::ST_REPORT;
                end else if (r_kind == hltp_pkg::KIND_SEARCH && !rd_word.valid) begin
                    n_res   = '{hltp_pkg::STATUS_MISSING, '0, '0};
                    n_state = hltp_pkg::ST_REPORT;
                end else if (r_kind == hltp_pkg::KIND_SEARCH && rd_word.key == r_key) begin
                    n_res   = '{hltp_pkg::STATUS_FOUND,
                                idx_wide[hltp_pkg::SLOT_W-1:0], rd_word.age};
                    n_state = hltp_pkg::ST_REPORT;
                end else if (r_step == LAST_IDX) begin
                    // whole table swept
                    if (r_kind == hltp_pkg::KIND_INSERT) begin
                        n_res = '{hltp_pkg::STATUS_FULL, '0, '0};
                    end else begin
                        n_res = '{hltp_pkg::STATUS_MISSING, '0, '0};
                    end
                    n_state = hltp_pkg::ST_REPORT;
                end else begin
                    n_step  = r_step + 1'b1;
                    n_idx   = idx_next;
                    n_state = hltp_pkg::ST_READ;
                end
            end
            hltp_pkg::ST_REPORT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = hltp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = hltp_pkg::ST_CLEAR;
                n_idx   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hltp_pkg::ST_CLEAR;
            r_idx   <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_count <= n_count;
        end
        r_step <= n_step;
        r_kind <= n_kind;
        r_key  <= n_key;
        r_age  <= n_age;
        r_res  <= n_res;
    end

    assign o_ram_addr  = r_idx;
    assign o_ram_wdata = wr_word;
    assign o_res       = r_res;

endmodule

// ----- hdl/hash_table_linear_probe_unit.sv -----
`timescale 1ns / 1ps
// Top level of the linear-probe hash table.
// Depends on hltp_pkg, hltp_home_div, hltp_slot_ram and hltp_probe_fsm.
//
// Open-addressing hash table of TABLE_SIZE slots with linear probing. Each
// input transaction is an insert (kind 0) or a search (kind 1) and yields
// exactly one result transaction: inserted with the slot written, table full,
// found with the slot and stored age, or not found. Keys, ages and valid
// marks live in one synchronous slot RAM. After reset the block runs a
// clearing pass over every RAM slot and holds o_stall high throughout.
// Transactions are handled one at a time: the home slot comes from a
// reciprocal-multiply remainder unit with a registered quotient and a
// registered remainder, then each probe is a RAM read state followed by a
// check state with possible write-back. An insert into a table whose count
// has reached TABLE_SIZE returns table full without probing. A finished
// result sits in an output register, so a new transaction is taken while
// the previous result still waits to be drained.
module hash_table_linear_probe_unit #(
    parameter int TABLE_SIZE = hltp_pkg::TABLE_SIZE_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_kind,
    input  logic [hltp_pkg::KEY_W-1:0]   i_key,
    input  logic [hltp_pkg::AGE_W-1:0]   i_age,
    // result channel
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [1:0]                   o_status,
    output logic [hltp_pkg::SLOT_W-1:0]  o_slot,
    output logic [hltp_pkg::AGE_W-1:0]   o_age_out
);

    localparam int IDX_W = $clog2(TABLE_SIZE);
    localparam int CNT_W = $clog2(TABLE_SIZE + 1);

    logic                        div_start, div_done;
    logic [IDX_W-1:0]            div_rem;
    logic                        ram_we, ram_re;
    logic [IDX_W-1:0]            ram_addr;
    logic [hltp_pkg::WORD_W-1:0] ram_wdata, ram_rdata;
    logic                        res_valid, res_ready;
    hltp_pkg::t_result           res;

    // output register
    logic                        r_out_valid, n_out_valid;
    hltp_pkg::t_result           r_out, n_out;

    hltp_home_div #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W)
    ) u_home_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_key   (i_key),
        .o_done  (div_done),
        .o_rem   (div_rem)
    );

    // Only one RAM access per cycle is issued, so the single address bus
    // serves both ports; reads and writes of one slot never overlap.
    hltp_slot_ram #(
        .DEPTH  (TABLE_SIZE),
        .ADDR_W (IDX_W),
        .DATA_W (hltp_pkg::WORD_W)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    hltp_probe_fsm #(
        .TABLE_SIZE (TABLE_SIZE),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_probe_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_stall  (o_stall),
        .i_kind      (i_kind),
        .i_key       (i_key),
        .i_age       (i_age),
        .o_div_start (div_start),
        .i_div_done  (div_done),
        .i_div_rem   (div_rem),
        .o_ram_we    (ram_we),
        .o_ram_addr  (ram_addr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .i_ram_rdata (ram_rdata),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Result moves in when the register is empty or being drained this cycle
    assign res_ready = !r_out_valid || !i_stall;

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (res_valid && res_ready) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_valid   = r_out_valid;
    assign o_status  = r_out.status;
    assign o_slot    = r_out.slot;
    assign o_age_out = r_out.age;

endmodule

// ----- hdl/hltp_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the linear-probe hash table, with its bind.
// Depends on hltp_pkg and hash_table_linear_probe_unit.
module hltp_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [1:0]                  o_status,
    input logic [hltp_pkg::SLOT_W-1:0] o_slot,
    input logic [hltp_pkg::AGE_W-1:0]  o_age_out
);

    // a held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_status) && $stable(o_slot) && $stable(o_age_out))
        else $error("stalled result changed");

    // one transaction in flight: stall rises right after acceptance
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second transaction taken while busy");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == hltp_pkg::STATUS_FULL || o_status == hltp_pkg::STATUS_MISSING)
        |-> o_slot == '0 && o_age_out == '0)
        else $error("full or miss result carries slot or age");

    a_ins_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == hltp_pkg::STATUS_INSERTED |-> o_age_out == '0)
        else $error("insert result carries age");

endmodule

bind hash_table_linear_probe_unit hltp_checker u_hltp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_stall   (o_stall),
    .o_valid   (o_valid),
    .i_stall   (i_stall),
    .o_status  (o_status),
    .o_slot    (o_slot),
    .o_age_out (o_age_out)
);
